[rtl/tfn_pkg.sv]
// Package with word types and width constants for the triangle face normal core.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

  // Lanes per item: the three normal components.
  localparam int unsigned LANES    = 3;
  // Edge, product and cross product widths.
  localparam int unsigned EDGE_W   = 17;
  localparam int unsigned PROD_W   = 34;
  localparam int unsigned CROSS_W  = 35;
  localparam int unsigned MAG_W    = 34;
  // Squares and their sum stay below 2^68.
  localparam int unsigned SUM_W    = 68;
  localparam int unsigned REM_W    = 69;
  // Quotient floor(2^30 * m^2 / S) is at most 2^30.
  localparam int unsigned QUO_W    = 31;
  localparam int unsigned ROOT_W   = 16;
  localparam int unsigned TRIAL_W  = 34;
  localparam int unsigned COMP_W   = 16;
  // One pipeline stage per quotient bit and per root bit.
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned ROOT_STEPS = 16;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
    logic signed [15:0] c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_word_t;

  // Work carried through the long division stages.
  typedef struct packed {
    logic [LANES-1:0][REM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [SUM_W-1:0]            sumsq;
    logic [LANES-1:0]            neg;
    logic                        degen;
  } div_word_t;

  // Work carried through the square root stages.
  typedef struct packed {
    logic [LANES-1:0][QUO_W-1:0]  rad;
    logic [LANES-1:0][ROOT_W-1:0] root;
    logic [LANES-1:0]             neg;
    logic                         degen;
  } root_word_t;

endpackage
`default_nettype wire

[rtl/tfn_front.sv]
// Front end: edges, cross product, squares and the sum of squares in five stages.
`timescale 1ns / 1ps
`default_nettype none
module tfn_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_in,
  input  wire tfn_pkg::in_word_t word_in,
  output logic                   valid_out,
  output tfn_pkg::div_word_t     word_out
);

  logic [4:0] valid_r;

  logic signed [tfn_pkg::EDGE_W-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [tfn_pkg::EDGE_W-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [tfn_pkg::PROD_W-1:0] prod_r [6];
  logic signed [tfn_pkg::PROD_W-1:0] prod_nxt [6];
  logic [tfn_pkg::LANES-1:0][tfn_pkg::MAG_W-1:0] mag_r, mag_nxt;
  logic [tfn_pkg::LANES-1:0] neg3_r, neg3_nxt, neg4_r;
  logic [tfn_pkg::LANES-1:0][tfn_pkg::SUM_W-1:0] sq_r, sq_nxt;
  tfn_pkg::div_word_t out_r, out_nxt;

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[3:0], valid_in};
    end
  end

  // Stage 1: edge vectors U = B - A and V = C - A.
  always_comb begin
    ux_nxt = 17'(word_in.b_x) - 17'(word_in.a_x);
    uy_nxt = 17'(word_in.b_y) - 17'(word_in.a_y);
    uz_nxt = 17'(word_in.b_z) - 17'(word_in.a_z);
    vx_nxt = 17'(word_in.c_x) - 17'(word_in.a_x);
    vy_nxt = 17'(word_in.c_y) - 17'(word_in.a_y);
    vz_nxt = 17'(word_in.c_z) - 17'(word_in.a_z);
  end

  // Stage 2: the six partial products of the cross product.
  always_comb begin
    prod_nxt[0] = 34'(uy_r) * 34'(vz_r);
    prod_nxt[1] = 34'(uz_r) * 34'(vy_r);
    prod_nxt[2] = 34'(uz_r) * 34'(vx_r);
    prod_nxt[3] = 34'(ux_r) * 34'(vz_r);
    prod_nxt[4] = 34'(ux_r) * 34'(vy_r);
    prod_nxt[5] = 34'(uy_r) * 34'(vx_r);
  end

  // Stage 3: cross product components as sign and magnitude.
  always_comb begin
    logic signed [tfn_pkg::CROSS_W-1:0] n;
    logic signed [tfn_pkg::CROSS_W-1:0] n_abs;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      n           = 35'(prod_r[2*k]) - 35'(prod_r[2*k+1]);
      n_abs       = n[tfn_pkg::CROSS_W-1] ? -n : n;
      neg3_nxt[k] = n[tfn_pkg::CROSS_W-1];
      mag_nxt[k]  = n_abs[tfn_pkg::MAG_W-1:0];
    end
  end

  // Stage 4: squares of the magnitudes.
  always_comb begin
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      sq_nxt[k] = 68'(mag_r[k]) * 68'(mag_r[k]);
    end
  end

  // Stage 5: sum of squares and the starting remainders of the division.
  always_comb begin
    out_nxt.sumsq = sq_r[0] + sq_r[1] + sq_r[2];
    out_nxt.degen = (out_nxt.sumsq == '0);
    out_nxt.neg   = neg4_r;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      out_nxt.rem[k] = 69'(sq_r[k]);
      out_nxt.quo[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      uz_r   <= uz_nxt;
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      vz_r   <= vz_nxt;
      prod_r <= prod_nxt;
      mag_r  <= mag_nxt;
      neg3_r <= neg3_nxt;
      sq_r   <= sq_nxt;
      neg4_r <= neg3_r;
      out_r  <= out_nxt;
    end
  end

  assign valid_out = valid_r[4];
  assign word_out  = out_r;

endmodule
`default_nettype wire

[rtl/tfn_div_stage.sv]
// One restoring division step per lane: yields one quotient bit of 2^30 * m^2 / S.
`timescale 1ns / 1ps
`default_nettype none
module tfn_div_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               valid_in,
  input  wire tfn_pkg::div_word_t word_in,
  output logic                    valid_out,
  output tfn_pkg::div_word_t      word_out
);

  logic               valid_r;
  tfn_pkg::div_word_t word_r, word_nxt;

  // Compare and subtract the divisor, then shift the remainder up.
  always_comb begin
    logic [tfn_pkg::REM_W-1:0] diff;
    logic                      take;
    word_nxt = word_in;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      take = (word_in.rem[k] >= 69'(word_in.sumsq));
      diff = take ? (word_in.rem[k] - 69'(word_in.sumsq)) : word_in.rem[k];
      word_nxt.rem[k] = {diff[tfn_pkg::REM_W-2:0], 1'b0};
      word_nxt.quo[k] = {word_in.quo[k][tfn_pkg::QUO_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule
`default_nettype wire

[rtl/tfn_root_stage.sv]
// One integer square root step per lane: decides root bit BIT.
`timescale 1ns / 1ps
`default_nettype none
module tfn_root_stage #(
  parameter int unsigned BIT = 15
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_in,
  input  wire tfn_pkg::root_word_t word_in,
  output logic                     valid_out,
  output tfn_pkg::root_word_t      word_out
);

  localparam logic [tfn_pkg::TRIAL_W-1:0] BIT_SQ = tfn_pkg::TRIAL_W'(1) << (2 * BIT);
  localparam logic [tfn_pkg::ROOT_W-1:0]  BIT_ONE = tfn_pkg::ROOT_W'(1) << BIT;

  logic                valid_r;
  tfn_pkg::root_word_t word_r, word_nxt;

  // (root + 2^b)^2 - root^2 = 2^(b+1) * root + 2^(2b), checked against D - root^2.
  always_comb begin
    logic [tfn_pkg::TRIAL_W-1:0] trial;
    word_nxt = word_in;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      trial = (tfn_pkg::TRIAL_W'(word_in.root[k]) << (BIT + 1)) + BIT_SQ;
      if (trial <= tfn_pkg::TRIAL_W'(word_in.rad[k])) begin
        word_nxt.rad[k]  = word_in.rad[k] - trial[tfn_pkg::QUO_W-1:0];
        word_nxt.root[k] = word_in.root[k] | BIT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule
`default_nettype wire

[rtl/triangle_face_normal_core.sv]
// Top level of the triangle face normal core: front end, division, square root, output.
// An accepted triangle passes the front end, the division stages, the square root stages and the output register.
// Throughput: one triangle per cycle while the output is not stalled.
// The whole pipeline advances together; a stalled output word holds every stage.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
// Exact arithmetic: q = floor((isqrt(floor(2^30 * m^2 / S)) + 1) / 2) per component.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tfn_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tfn_pkg::out_word_t      out_word
);

  logic en;

  logic               div_valid [tfn_pkg::DIV_STEPS+1];
  tfn_pkg::div_word_t div_word  [tfn_pkg::DIV_STEPS+1];
  logic                root_valid [tfn_pkg::ROOT_STEPS+1];
  tfn_pkg::root_word_t root_word  [tfn_pkg::ROOT_STEPS+1];

  logic               out_valid_r;
  tfn_pkg::out_word_t out_word_r, out_word_nxt;

  // Pipeline moves whenever the output register is free or being taken.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  tfn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_valid),
    .word_in   (in_word),
    .valid_out (div_valid[0]),
    .word_out  (div_word[0])
  );

  // Long division, one quotient bit per stage.
  for (genvar i = 0; i < tfn_pkg::DIV_STEPS; i++) begin : g_div
    tfn_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (div_valid[i]),
      .word_in   (div_word[i]),
      .valid_out (div_valid[i+1]),
      .word_out  (div_word[i+1])
    );
  end

  // Hand the quotients over to the square root chain.
  always_comb begin
    root_valid[0]      = div_valid[tfn_pkg::DIV_STEPS];
    root_word[0].neg   = div_word[tfn_pkg::DIV_STEPS].neg;
    root_word[0].degen = div_word[tfn_pkg::DIV_STEPS].degen;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      root_word[0].rad[k]  = div_word[tfn_pkg::DIV_STEPS].quo[k];
      root_word[0].root[k] = '0;
    end
  end

  // Square root, most significant root bit first.
  for (genvar j = 0; j < tfn_pkg::ROOT_STEPS; j++) begin : g_root
    tfn_root_stage #(
      .BIT (tfn_pkg::ROOT_STEPS - 1 - j)
    ) u_root (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (root_valid[j]),
      .word_in   (root_word[j]),
      .valid_out (root_valid[j+1]),
      .word_out  (root_word[j+1])
    );
  end

  // Round to the nearest code, apply the sign, and zero a degenerate normal.
  always_comb begin
    logic [tfn_pkg::ROOT_W:0]      half;
    logic [tfn_pkg::LANES-1:0][tfn_pkg::COMP_W-1:0] comp;
    for (int k = 0; k < tfn_pkg::LANES; k++) begin
      half    = (17'(root_word[tfn_pkg::ROOT_STEPS].root[k]) + 17'd1) >> 1;
      comp[k] = root_word[tfn_pkg::ROOT_STEPS].neg[k] ? (16'd0 - half[tfn_pkg::COMP_W-1:0])
                                                      : half[tfn_pkg::COMP_W-1:0];
      if (root_word[tfn_pkg::ROOT_STEPS].degen) begin
        comp[k] = '0;
      end
    end
    out_word_nxt.normal_x   = comp[0];
    out_word_nxt.normal_y   = comp[1];
    out_word_nxt.normal_z   = comp[2];
    out_word_nxt.degenerate = root_word[tfn_pkg::ROOT_STEPS].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= root_valid[tfn_pkg::ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A degenerate triangle gives an all-zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.degenerate |->
      out_word_r.normal_x == 16'sd0 && out_word_r.normal_y == 16'sd0 &&
      out_word_r.normal_z == 16'sd0)
    else $error("degenerate word with nonzero normal");

  // A unit normal always has a nonzero component.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.degenerate |->
      out_word_r.normal_x != 16'sd0 || out_word_r.normal_y != 16'sd0 ||
      out_word_r.normal_z != 16'sd0)
    else $error("valid triangle gave a zero normal");

  // Components stay within plus or minus one in Q1.14.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      out_word_r.normal_x <= 16'sd16384 && out_word_r.normal_x >= -16'sd16384 &&
      out_word_r.normal_y <= 16'sd16384 && out_word_r.normal_y >= -16'sd16384 &&
      out_word_r.normal_z <= 16'sd16384 && out_word_r.normal_z >= -16'sd16384)
    else $error("normal component out of range");

  // Reset leaves no word on the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
